FILE: hdl/wrv_pkg.sv
// Package for the weighted running variance block: widths, state codes, command struct.
// No dependencies.
`default_nettype none
package wrv_pkg;
  localparam int unsigned DataW      = 64;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned MulDigW    = 16;
  localparam int unsigned DefCounters = 16;
  localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LATCH, ST_CHECK, ST_SCALE, ST_RATE, ST_MEAN, ST_D1, ST_D2,
    ST_VAR, ST_SQRT, ST_UNC, ST_OUT
  } wrv_state_t;

  typedef struct packed {
    logic load;       // capture input transaction
    logic rd;         // register table entry
    logic latch;      // take entry into working registers
    logic mul_start;  // launch a multiplication
    logic [1:0] mul_sel;
    logic div_start;  // launch a division
    logic [1:0] div_sel;
    logic upd;        // update total and weight
    logic set_rate;
    logic set_mean;
    logic set_acc;
    logic set_var;
    logic sqrt_start;
    logic set_unc;
    logic wr;         // write entry back
    logic out_load;
  } wrv_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic bad_idx;
    logic pinned;
    logic zero_time;
  } wrv_sts_t;

  localparam logic [1:0] DIV_RATE = 2'd0;
  localparam logic [1:0] DIV_MEAN = 2'd1;
  localparam logic [1:0] DIV_VAR  = 2'd2;

  localparam logic [1:0] MUL_SCALE = 2'd0;
  localparam logic [1:0] MUL_D1    = 2'd1;
  localparam logic [1:0] MUL_D2    = 2'd2;
  localparam logic [1:0] MUL_UNC   = 2'd3;
endpackage
`default_nettype wire

FILE: hdl/wrv_ram.sv
// Generic RAM with one write port and one read port, registered read.
// No dependencies.
`default_nettype none
module wrv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/wrv_div.sv
// Restoring 64-bit divider, one quotient bit per cycle; all ones on a zero divisor.
// Depends on wrv_pkg.
`default_nettype none
module wrv_div
  import wrv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DataW-1:0] num,
  input  wire logic [DataW-1:0] den,
  output logic                  done,
  output logic [DataW-1:0]      quot
);
  localparam int unsigned CntW = $clog2(DataW) + 1;
  logic [DataW-1:0] q_r, q_nxt, d_r;
  logic [DataW:0]   rem_r, rem_nxt, trial;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, zero_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[DataW-1:0], q_r[DataW-1]} - {1'b0, d_r};
    if (busy_r) begin
      if (!trial[DataW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DataW-1:0], q_r[DataW-1]};
        q_nxt = {q_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && (cnt_r == CntW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DataW);
      end else begin
        busy_r <= busy_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= num;
      d_r    <= den;
      rem_r  <= '0;
      zero_r <= (den == '0);
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = zero_r ? AllOnes : q_r;
endmodule
`default_nettype wire

FILE: hdl/wrv_sqrt.sv
// Bit-by-bit integer square root of a 64-bit value, one result bit per cycle.
// Depends on wrv_pkg.
`default_nettype none
module wrv_sqrt
  import wrv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DataW-1:0] val,
  output logic                  done,
  output logic [DataW/2-1:0]    root
);
  localparam int unsigned Steps = DataW / 2;
  localparam int unsigned CntW  = $clog2(Steps) + 1;
  logic [DataW-1:0]  v_r;
  logic [DataW/2+1:0] rem_r, trial;
  logic [DataW/2-1:0] root_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;

  assign trial = {rem_r[DataW/2-1:0], v_r[DataW-1:DataW-2]} - {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && (cnt_r == CntW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(Steps);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r <= {v_r[DataW-3:0], 2'b00};
      if (!trial[DataW/2+1]) begin
        rem_r  <= trial;
        root_r <= {root_r[DataW/2-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[DataW/2-1:0], v_r[DataW-1:DataW-2]};
        root_r <= {root_r[DataW/2-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
endmodule
`default_nettype wire

FILE: hdl/wrv_ctrl.sv
// Sequencer for one statistics update: reads entry, runs multiplications, divisions and square root, writes back.
// Depends on wrv_pkg.
`default_nettype none
module wrv_ctrl
  import wrv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire wrv_sts_t sts,
  output wrv_cmd_t  cmd,
  output logic      busy
);
  wrv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.latch = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.bad_idx || sts.zero_time || sts.pinned) begin
          cmd.sqrt_start = 1'b1;
          state_nxt = ST_SQRT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MUL_SCALE;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (sts.mul_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_RATE;
          cmd.upd = 1'b1;
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        if (sts.div_done) begin
          cmd.set_rate = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_MEAN;
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (sts.div_done) begin
          cmd.set_mean = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MUL_D1;
          state_nxt = ST_D1;
        end
      end
      ST_D1: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MUL_D2;
          state_nxt = ST_D2;
        end
      end
      ST_D2: begin
        if (sts.mul_done) begin
          cmd.set_acc = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_VAR;
          state_nxt = ST_VAR;
        end
      end
      ST_VAR: begin
        if (sts.div_done) begin
          cmd.set_var = 1'b1;
          cmd.sqrt_start = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MUL_UNC;
          state_nxt = ST_UNC;
        end
      end
      ST_UNC: begin
        if (sts.mul_done) begin
          cmd.set_unc = 1'b1;
          cmd.wr = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/wrv_dp.sv
// Datapath: statistics table, digit-serial multiplier, divider and square root unit.
// Depends on wrv_pkg, wrv_ram, wrv_div, wrv_sqrt.
`default_nettype none
module wrv_dp
  import wrv_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = DefCounters
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wrv_cmd_t          cmd,
  input  wire logic [IdxW-1:0]   in_idx,
  input  wire logic [DataW-1:0]  in_count,
  input  wire logic [DataW-1:0]  in_time,
  input  wire logic              in_pinned,
  input  wire logic [DataW-1:0]  in_unmon,
  input  wire logic [ScaleW-1:0] scale,
  output wrv_sts_t               sts,
  output logic [IdxW-1:0]        res_idx,
  output logic [DataW-1:0]       res_mean,
  output logic [DataW-1:0]       res_var,
  output logic [DataW-1:0]       res_unc,
  output logic                   res_skip
);
  localparam int unsigned AW = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int unsigned EW = 5 * DataW;
  localparam int unsigned MulSteps = DataW / MulDigW;
  localparam int unsigned MCntW = $clog2(MulSteps) + 1;

  logic [IdxW-1:0]  idx_r;
  logic [DataW-1:0] cnt_r, time_r, unmon_r, rate_r;
  logic             pin_r;
  logic [DataW-1:0] tot_r, wt_r, mean_r, old_r, acc_r, var_r, unc_r;
  logic [DataW/2-1:0] root;
  logic [EW-1:0]    rd_data;
  logic [NUM_COUNTERS-1:0] valid_r;
  logic [AW-1:0]    addr;
  logic             bad;
  logic [DataW-1:0] div_num, div_den, quot, sqrt_val, acc_sum;
  logic             div_done, sqrt_done;
  logic [DataW-1:0] rd_tot, rd_wt, rd_mean, rd_acc, rd_var;
  logic             ent_valid_r;
  logic [DataW-1:0] mul_a, mul_b, ma_r, mb_r, mp_r;
  logic [MCntW-1:0] mcnt_r;
  logic             mbusy_r, mul_done_r;

  assign bad  = ({{(32-IdxW){1'b0}}, idx_r} >= 32'(NUM_COUNTERS));
  assign addr = AW'(idx_r);

  wrv_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_tab (
    .clk(clk), .we(cmd.wr && !bad), .waddr(addr),
    .wdata({tot_r, wt_r, mean_r, acc_r, var_r}), .raddr(addr), .rdata(rd_data)
  );

  assign {rd_tot, rd_wt, rd_mean, rd_acc, rd_var} =
    ent_valid_r ? rd_data : '0;

  assign acc_sum = acc_r + mp_r;

  always_comb begin
    div_num = acc_sum;
    div_den = wt_r;
    unique case (cmd.div_sel)
      DIV_RATE: begin div_num = mp_r;    div_den = time_r; end
      DIV_MEAN: begin div_num = tot_r;   div_den = wt_r;   end
      default:  begin div_num = acc_sum; div_den = wt_r;   end
    endcase
  end

  // D1 starts while the new mean is still on the divider output
  always_comb begin
    mul_a = unmon_r;
    mul_b = DataW'(root);
    unique case (cmd.mul_sel)
      MUL_SCALE: begin mul_a = cnt_r;   mul_b = DataW'(scale);  end
      MUL_D1:    begin mul_a = time_r;  mul_b = rate_r - quot;  end
      MUL_D2:    begin mul_a = mp_r;    mul_b = rate_r - old_r; end
      MUL_UNC:   begin mul_a = unmon_r; mul_b = DataW'(root);   end
    endcase
  end

  assign sqrt_val = cmd.set_var ? quot : var_r;

  wrv_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
    .den(div_den), .done(div_done), .quot(quot));

  wrv_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .val(sqrt_val),
    .done(sqrt_done), .root(root));

  // multiplier: one 16-bit digit of b per cycle, low 64 bits of the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r    <= 1'b0;
      mcnt_r     <= '0;
      mul_done_r <= 1'b0;
    end else begin
      mul_done_r <= mbusy_r && (mcnt_r == MCntW'(1));
      if (cmd.mul_start) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= MCntW'(MulSteps);
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r - 1'b1;
        if (mcnt_r == MCntW'(1)) begin
          mbusy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r <= mul_a;
      mb_r <= mul_b;
      mp_r <= '0;
    end else if (mbusy_r) begin
      mp_r <= mp_r + ma_r * mb_r[MulDigW-1:0];
      ma_r <= ma_r << MulDigW;
      mb_r <= mb_r >> MulDigW;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.mul_done  = mul_done_r;
  assign sts.sqrt_done = sqrt_done;
  assign sts.bad_idx   = bad;
  assign sts.pinned    = pin_r;
  assign sts.zero_time = (time_r == '0) && !pin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ent_valid_r <= 1'b0;
    end else begin
      if (cmd.wr && !bad) begin
        valid_r[addr] <= 1'b1;
      end
      if (cmd.load) begin
        ent_valid_r <= 1'b0;
      end else if (cmd.rd) begin
        ent_valid_r <= !bad && valid_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_idx;
      cnt_r   <= in_count;
      time_r  <= in_time;
      pin_r   <= in_pinned;
      unmon_r <= in_unmon;
    end
    if (cmd.latch) begin
      tot_r  <= bad ? '0 : rd_tot;
      wt_r   <= bad ? '0 : rd_wt;
      mean_r <= bad ? '0 : rd_mean;
      acc_r  <= bad ? '0 : rd_acc;
      var_r  <= bad ? '0 : (pin_r ? AllOnes : rd_var);
    end else begin
      if (cmd.upd) begin
        tot_r <= tot_r + mp_r;
        wt_r  <= wt_r + time_r;
      end
      if (cmd.set_mean) begin
        mean_r <= quot;
      end
      if (cmd.set_acc) begin
        acc_r <= acc_sum;
      end
      if (cmd.set_var) begin
        var_r <= quot;
      end
    end
    if (cmd.upd) begin
      old_r <= mean_r;
    end
    if (cmd.set_rate) begin
      rate_r <= quot;
    end
    if (cmd.set_unc) begin
      unc_r <= mp_r;
    end
  end

  assign res_idx  = idx_r;
  assign res_mean = bad ? '0 : mean_r;
  assign res_var  = bad ? '0 : var_r;
  assign res_unc  = bad ? '0 : unc_r;
  assign res_skip = bad || (!pin_r && time_r == '0);
endmodule
`default_nettype wire

FILE: hdl/weighted_running_variance.sv
// Top level of the weighted running variance block: handshakes, rate_scale register, output register.
// Depends on wrv_pkg, wrv_ctrl, wrv_dp.
//  channel | dir | payload
//  in_     | in  | tdata: counter_index, event_count, observed_time, unmonitored_time; tuser: pinned
//  out_    | out | tdata: out_index, mean_rate, variance, uncertainty; tuser: skipped
//  cfg_    | in  | rate_scale, 32 bits
// An update runs three divisions, a square root and four multiplications, in sequence.
// Pinned, zero-time and out-of-range items run only the square root and one multiplication.
// One item at a time; in_tready is low while an item is at work.
// The output register holds a result while out_tready is low; the next item is taken meanwhile.
// Synchronous active-low reset clears the table (valid bits) and sets rate_scale to 1.
`default_nettype none
module weighted_running_variance
  import wrv_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = DefCounters
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [199:0] in_tdata,  // counter_index, event_count, observed_time, unmonitored_time
  input  wire logic         in_tuser,  // pinned
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata, // out_index, mean_rate, variance, uncertainty
  output logic              out_tuser, // skipped
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);
  logic [ScaleW-1:0] scale_r;
  wrv_cmd_t cmd;
  wrv_sts_t sts;
  logic busy, in_fire, out_free;
  logic [IdxW-1:0]  r_idx;
  logic [DataW-1:0] r_mean, r_var, r_unc;
  logic             r_skip;

  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = !busy;
  assign out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ScaleW'(1);
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  wrv_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy));

  wrv_dp #(.NUM_COUNTERS(NUM_COUNTERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_idx(in_tdata[3:0]), .in_count(in_tdata[67:4]), .in_time(in_tdata[131:68]),
    .in_pinned(in_tuser), .in_unmon(in_tdata[195:132]), .scale(scale_r), .sts(sts),
    .res_idx(r_idx), .res_mean(r_mean), .res_var(r_var), .res_unc(r_unc),
    .res_skip(r_skip));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {4'b0, r_unc, r_var, r_mean, r_idx};
      out_tuser <= r_skip;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("input taken while busy");
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready)) else $error("result overwritten");
  a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !cmd.sqrt_start) else $error("units started together");
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for weighted_running_variance: per-counter weighted rate statistics.
// Depends on wrv_pkg and the RTL. It predicts every result with its own model of the table
// and checks each output transaction against the oldest prediction.
`default_nettype none
module tb_top
  import wrv_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCtr = DefCounters;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] mean;
    logic [DataW-1:0] var_v;
    logic [DataW-1:0] unc;
    logic             skip;
  } stats_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [199:0]       in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [199:0]       out_tdata;
  logic               out_tuser;
  logic               cfg_we = 1'b0;
  logic [ScaleW-1:0]  cfg_wdata = '0;

  weighted_running_variance #(.NUM_COUNTERS(NumCtr)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // model of the table
  logic [DataW-1:0]  m_total [NumCtr];
  logic [DataW-1:0]  m_weight[NumCtr];
  logic [DataW-1:0]  m_mean  [NumCtr];
  logic [DataW-1:0]  m_acc   [NumCtr];
  logic [DataW-1:0]  m_var   [NumCtr];
  logic [ScaleW-1:0] m_scale;

  stats_res_t pending_stats[$];
  int unsigned n_sent, n_checked, n_err, n_pinned, n_zero, n_cfg;
  int unsigned burst_left, idle_cycles;
  bit timed_out;

  function automatic logic [DataW-1:0] floor_sqrt(logic [DataW-1:0] v);
    logic [DataW-1:0]   root;
    logic [DataW-1:0]   trial;
    logic [2*DataW-1:0] sq;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      sq = trial * trial;
      if (sq <= {64'd0, v}) root = trial;
    end
    return root;
  endfunction

  function automatic logic [DataW-1:0] div_or_ones(logic [DataW-1:0] n, logic [DataW-1:0] d);
    return (d == '0) ? AllOnes : n / d;
  endfunction

  function automatic stats_res_t update_stats(logic [IdxW-1:0] idx, logic [DataW-1:0] cnt,
                                              logic [DataW-1:0] tm, logic pin,
                                              logic [DataW-1:0] unmon);
    stats_res_t r;
    logic [DataW-1:0] scaled, rate, prev_mean, term;
    r.idx = idx;
    r.skip = 1'b0;
    if (pin) begin
      m_var[idx] = AllOnes;
    end else if (tm == '0) begin
      r.skip = 1'b1;
    end else begin
      scaled = cnt * {32'd0, m_scale};
      rate = scaled / tm;
      prev_mean = m_mean[idx];
      m_total[idx] = m_total[idx] + scaled;
      m_weight[idx] = m_weight[idx] + tm;
      m_mean[idx] = div_or_ones(m_total[idx], m_weight[idx]);
      term = tm * (rate - m_mean[idx]);
      term = term * (rate - prev_mean);
      m_acc[idx] = m_acc[idx] + term;
      m_var[idx] = div_or_ones(m_acc[idx], m_weight[idx]);
    end
    r.mean = m_mean[idx];
    r.var_v = m_var[idx];
    r.unc = floor_sqrt(m_var[idx]) * unmon;
    return r;
  endfunction

  function automatic logic [DataW-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic [IdxW-1:0] idx, logic [DataW-1:0] cnt, logic [DataW-1:0] tm,
                           logic pin, logic [DataW-1:0] unmon);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, unmon, tm, cnt, idx};
    in_tuser <= pin;
    do @(posedge clk); while (!in_tready);
    pending_stats.push_back(update_stats(idx, cnt, tm, pin, unmon));
    n_sent++;
    if (pin) n_pinned++;
    else if (tm == '0) n_zero++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_scale(logic [ScaleW-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_scale = v;
    n_cfg++;
  endtask

  task automatic test_field_extremes();
    send_item(4'd0, 64'd100, 64'd10, 1'b0, 64'd7);
    send_item(4'd0, 64'd300, 64'd10, 1'b0, 64'd3);
    send_item(4'd15, AllOnes, 64'd1, 1'b0, AllOnes);
    send_item(4'd15, AllOnes, AllOnes, 1'b0, AllOnes);
    send_item(4'd1, 64'd0, AllOnes, 1'b0, 64'd0);
    send_item(4'd2, 64'd5, 64'd1, 1'b0, 64'd1);
    send_item(4'd2, AllOnes, 64'd2, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(4'd3, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
              64'h5555_5555_5555_5555);
  endtask

  task automatic test_pin_and_skip();
    send_item(4'd0, 64'd1, 64'd0, 1'b0, 64'd9);
    send_item(4'd0, 64'd1, 64'd0, 1'b1, 64'd9);
    send_item(4'd0, 64'd50, 64'd5, 1'b1, AllOnes);
    send_item(4'd0, 64'd80, 64'd4, 1'b0, 64'd2);
    send_item(4'd4, 64'd0, 64'd0, 1'b0, AllOnes);
    send_item(4'd5, 64'd1, 64'd1, 1'b1, 64'd1);
    // weight wraps to zero: divisions by the weight give all ones
    send_item(4'd6, 64'd10, 64'h8000_0000_0000_0000, 1'b0, 64'd1);
    send_item(4'd6, 64'd10, 64'h8000_0000_0000_0000, 1'b0, 64'd1);
    send_item(4'd6, 64'd0, 64'd0, 1'b0, 64'd3);
  endtask

  task automatic test_scale_extremes();
    set_scale(32'hFFFF_FFFF);
    send_item(4'd7, 64'd3, 64'd2, 1'b0, 64'd1);
    send_item(4'd7, AllOnes, 64'd3, 1'b0, 64'd11);
    send_item(4'd8, 64'h1_0000_0001, 64'd1, 1'b0, AllOnes);
    set_scale(32'd1);
    send_item(4'd7, 64'd9, 64'd1, 1'b0, 64'd1);
  endtask

  task automatic send_random(int unsigned n, int unsigned idx_hi);
    logic [DataW-1:0] cnt, tm, unmon;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 15) begin
        cnt = rnd64(); tm = rnd64(); unmon = rnd64();
      end else begin
        cnt = DataW'($urandom_range(0, 100000));
        tm = DataW'($urandom_range(1, 5000));
        unmon = DataW'($urandom_range(0, 1000));
      end
      if (k >= 90) tm = '0;
      send_item(IdxW'($urandom_range(0, idx_hi)), cnt, tm, (k >= 84 && k < 90), unmon);
    end
  endtask

  task automatic test_random_scales();
    set_scale($urandom_range(2, 1000));
    send_random(430, 3);
    set_scale($urandom);
    send_random(430, NumCtr - 1);
    set_scale(32'd1);
    send_random(430, NumCtr - 1);
  endtask

  task automatic test_drain_pause();
    send_random(20, 1);
    drain();
    send_random(400, NumCtr - 1);
  endtask

  // result checker
  always @(posedge clk) begin
    stats_res_t exp_r, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[3:0], out_tdata[67:4], out_tdata[131:68], out_tdata[195:132], out_tuser};
      n_checked++;
      if (pending_stats.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        exp_r = pending_stats.pop_front();
        if (got != exp_r) begin
          n_err++;
          if (n_err <= 10) begin
            $display("result %0d mismatch", n_checked);
            $display("  idx  exp %0d got %0d", exp_r.idx, got.idx);
            $display("  mean exp %h got %h", exp_r.mean, got.mean);
            $display("  var  exp %h got %h", exp_r.var_v, got.var_v);
            $display("  unc  exp %h got %h", exp_r.unc, got.unc);
            $display("  skip exp %b got %b", exp_r.skip, got.skip);
          end
        end
      end
    end
  end

  // receiver back-pressure: free-running stretches and random stall phases
  int unsigned stall_mode, mode_left;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 600);
    end
    mode_left--;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d results outstanding", pending_stats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumCtr; i++) begin
      m_total[i] = '0; m_weight[i] = '0; m_mean[i] = '0; m_acc[i] = '0; m_var[i] = '0;
    end
    m_scale = 32'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_pin_and_skip();
    test_scale_extremes();
    test_random_scales();
    test_drain_pause();
    drain();
    if (pending_stats.size() != 0) n_err++;
    $display("%0d transactions sent (%0d pinned, %0d zero-time), %0d results checked",
             n_sent, n_pinned, n_zero, n_checked);
    $display("%0d rate_scale writes; %0d errors", n_cfg, n_err);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
